### rtl/core/kpre_pkg.sv
package kpre_pkg;

  localparam int MODE_W   = 1;
  localparam int IDX_W    = 6;
  localparam int REM_W    = 48;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 56;
  localparam int STATUS_W = 3;

  localparam int TBYTES_W = 64;
  localparam int TTIME_W  = 48;
  localparam int SREM_W   = REM_W - 1;

  // 1000 * total_bytes needs ten more bits
  localparam int SCALE_SH = 10;
  localparam int NUM_W    = TBYTES_W + SCALE_SH;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ELAPSED  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DEFAULT_RATE_RST = 48'd20000000;
  localparam logic [TIME_W-1:0]     MIN_ELAPSED_RST  = 32'd10000;

  localparam logic [MODE_W-1:0] MODE_UPDATE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_UPDATED  = 3'd0,
    STAT_NEW_SLOT = 3'd1,
    STAT_NONPOS   = 3'd2,
    STAT_GREW     = 3'd3,
    STAT_NOT_ADV  = 3'd4,
    STAT_REMOVED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_ACC,
    S_SCALE,
    S_DIV,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic              valid;
    logic [SREM_W-1:0] remaining;
    logic [TIME_W-1:0] stamp;
  } slot_entry_t;

endpackage

### rtl/core/keyed_progress_rate_estimator_unit.sv
// Keyed progress rate estimator.
// Input channel (in_valid / in_stall): one item per job report. mode selects
// an update of slot_index with remaining_bytes at now_time, or a removal.
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in order: rate (bytes per time unit x1000, saturating), status and,
// for removals, whether the slot held an entry.
// Config channel (cfg_valid / cfg_ready): index 0 default_rate, 1
// min_elapsed; cfg_ready is always high, write only while idle.
// Timing: an item goes through one slot memory read, a write-back step and a
// sum update. When the answer is a ratio, a radix-2 restoring divider takes
// one quotient bit per cycle over the 74-bit dividend 1000*total_bytes.
// From accept an item passes S_EVAL and S_ACC, for a ratio also S_SCALE and
// S_DIV, then S_DONE. The next item is taken in the cycle after the result is loaded.
// A finished result sits in the output register; a new item is accepted
// while it waits. When the receiver stalls and a second result is ready, the
// block holds it and keeps in_stall high until the output register frees.
// Reset: config registers and the two sums return to their defaults, then a
// clearing pass marks every slot empty; in_stall is high during that pass.
module keyed_progress_rate_estimator_unit #(
  parameter int SLOTS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [kpre_pkg::MODE_W-1:0]           mode,
  input  logic [kpre_pkg::IDX_W-1:0]            slot_index,
  input  logic signed [kpre_pkg::REM_W-1:0]     remaining_bytes,
  input  logic [kpre_pkg::TIME_W-1:0]           now_time,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [kpre_pkg::RATE_W-1:0]           rate,
  output logic [kpre_pkg::STATUS_W-1:0]         status,
  output logic                                  existed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kpre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kpre_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kpre_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // control state
  fsm_state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [CNT_W-1:0] cnt;

  // configuration
  logic [CFG_DATA_W-1:0] default_rate;
  logic [TIME_W-1:0]     min_elapsed;

  // global sums
  logic [TBYTES_W-1:0] total_bytes;
  logic [TTIME_W-1:0]  total_time;

  // slot memory
  slot_entry_t slot_mem [SLOTS];
  slot_entry_t rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  slot_entry_t mem_wdata;

  // captured item
  logic [MODE_W-1:0] mode_q;
  logic [AW-1:0]     idx_q;
  logic              in_range_q;
  logic [REM_W-1:0]  rem_q;
  logic [TIME_W-1:0] now_q;

  // evaluation results
  status_t           stat_q;
  logic              existed_q;
  logic [SREM_W-1:0] dx_q;
  logic [TIME_W-1:0] dt_q;
  logic              use_div_q;

  // divider
  logic [NUM_W-1:0]   num;
  logic [TTIME_W-1:0] den;
  logic [TTIME_W-1:0] rem_acc;
  logic [NUM_W-1:0]   quo;

  // output register
  logic [RATE_W-1:0] rate_out;
  status_t           status_out;
  logic              existed_out;

  logic in_accept;
  logic out_free;
  logic load_out;
  logic clr_last;
  logic div_last;

  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]       in_addr;
  logic                in_range;

  // eval combinational
  status_t     ev_stat;
  logic        ev_existed;
  logic        ev_we;
  slot_entry_t ev_wdata;
  logic        ev_use_div;
  logic        rem_nonpos;

  // accumulate / divide combinational
  logic [TBYTES_W:0]  sum_b;
  logic [TTIME_W:0]   sum_t;
  logic [NUM_W-1:0]   tb_ext;
  logic [TTIME_W:0]   trial;
  logic [TTIME_W+1:0] diff;
  logic               ge;
  logic [RATE_W-1:0]  q_sat;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign clr_last  = (clr_addr == AW'(SLOTS - 1));
  assign div_last  = (cnt == CNT_W'(DIV_STEPS - 1));

  assign idx_ext  = {{AW{1'b0}}, slot_index};
  assign in_addr  = idx_ext[AW-1:0];
  assign in_range = (32'(slot_index) < 32'(SLOTS));

  assign rate    = rate_out;
  assign status  = status_out;
  assign existed = existed_out;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (in_accept) state_next = S_EVAL;
      S_EVAL:  state_next = S_ACC;
      S_ACC:   state_next = use_div_q ? S_SCALE : S_DONE;
      S_SCALE: state_next = S_DIV;
      S_DIV:   if (div_last) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    load_out  = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_EVAL: begin
        mem_we    = ev_we;
        mem_waddr = idx_q;
        mem_wdata = ev_wdata;
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // slot evaluation against the stored entry
  always_comb begin
    rem_nonpos = (rem_q == '0) || rem_q[REM_W-1];
    ev_existed = 1'b0;
    ev_we      = 1'b0;
    ev_wdata   = '{valid: 1'b1, remaining: rem_q[SREM_W-1:0], stamp: now_q};
    if (mode_q == MODE_REMOVE) begin
      ev_stat    = STAT_REMOVED;
      ev_existed = in_range_q && rd_data.valid;
      ev_we      = in_range_q;
      ev_wdata   = '{valid: 1'b0, remaining: rd_data.remaining, stamp: rd_data.stamp};
    end else if (rem_nonpos) begin
      ev_stat = STAT_NONPOS;
    end else if (!in_range_q) begin
      ev_stat = STAT_NEW_SLOT;
    end else if (!rd_data.valid) begin
      ev_stat = STAT_NEW_SLOT;
      ev_we   = 1'b1;
    end else if (rd_data.remaining < rem_q[SREM_W-1:0]) begin
      ev_stat = STAT_GREW;
    end else if (rd_data.stamp >= now_q) begin
      ev_stat = STAT_NOT_ADV;
    end else begin
      ev_stat = STAT_UPDATED;
      ev_we   = 1'b1;
    end
    // ratio needed for a fresh update, or when the old sums are trusted
    ev_use_div = (ev_stat == STAT_UPDATED) ||
                 ((total_time > TTIME_W'(min_elapsed)) &&
                  (total_bytes > TBYTES_W'(default_rate)));
  end

  // saturating sums, scaling and one divide step
  always_comb begin
    sum_b  = {1'b0, total_bytes} + (TBYTES_W + 1)'(dx_q);
    sum_t  = {1'b0, total_time} + (TTIME_W + 1)'(dt_q);
    tb_ext = NUM_W'(total_bytes);
    trial  = {rem_acc, num[NUM_W-1]};
    diff   = {1'b0, trial} - {2'b00, den};
    ge     = !diff[TTIME_W+1];
    q_sat  = (|quo[NUM_W-1:RATE_W]) ? {RATE_W{1'b1}} : quo[RATE_W-1:0];
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_data <= slot_mem[in_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      cnt          <= '0;
      default_rate <= DEFAULT_RATE_RST;
      min_elapsed  <= MIN_ELAPSED_RST;
      total_bytes  <= '0;
      total_time   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEFAULT_RATE: default_rate <= cfg_data;
          REG_MIN_ELAPSED:  min_elapsed  <= cfg_data[TIME_W-1:0];
          default:          default_rate <= default_rate;
        endcase
      end
      if (state == S_ACC && stat_q == STAT_UPDATED) begin
        total_bytes <= sum_b[TBYTES_W] ? {TBYTES_W{1'b1}} : sum_b[TBYTES_W-1:0];
        total_time  <= sum_t[TTIME_W] ? {TTIME_W{1'b1}} : sum_t[TTIME_W-1:0];
      end
      if (state == S_SCALE) begin
        cnt <= '0;
      end else if (state == S_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q     <= mode;
      idx_q      <= in_addr;
      in_range_q <= in_range;
      rem_q      <= remaining_bytes;
      now_q      <= now_time;
    end
    if (state == S_EVAL) begin
      stat_q    <= ev_stat;
      existed_q <= ev_existed;
      use_div_q <= ev_use_div;
      dx_q      <= rd_data.remaining - rem_q[SREM_W-1:0];
      dt_q      <= now_q - rd_data.stamp;
    end
    if (state == S_SCALE) begin
      // 1000*x = 1024*x - 16*x - 8*x
      num     <= (tb_ext << 10) - (tb_ext << 4) - (tb_ext << 3);
      den     <= total_time;
      rem_acc <= '0;
      quo     <= '0;
    end else if (state == S_DIV) begin
      rem_acc <= ge ? diff[TTIME_W-1:0] : trial[TTIME_W-1:0];
      quo     <= {quo[NUM_W-2:0], ge};
      num     <= {num[NUM_W-2:0], 1'b0};
    end
    if (load_out) begin
      rate_out    <= use_div_q ? q_sat : RATE_W'(default_rate);
      status_out  <= stat_q;
      existed_out <= existed_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the done state");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_EVAL)
    else $error("accepted item did not enter evaluation");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != '0)
    else $error("divide by zero time sum");

  a_bytes_grow: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> total_bytes >= $past(total_bytes))
    else $error("byte sum decreased");

  a_mem_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_EVAL))
    else $error("slot memory written in a wrong state");
`endif

endmodule
